FILE: design/periodic_heap_scheduler_defines.svh
// Assertion macros shared by the periodic heap scheduler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PERIODIC_HEAP_SCHEDULER_DEFINES_SVH
`define PERIODIC_HEAP_SCHEDULER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/phs_pkg.sv
// Types and codes for the periodic heap scheduler.
// No dependencies; imported by phs_cmp and periodic_heap_scheduler.
`default_nettype none

package phs_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned IdW     = 32;
  localparam int unsigned PeriodW = 16;

  // transaction kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_NEXT  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SENT  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  localparam logic [TimeW-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IdW-1:0]     client_id;
    logic [PeriodW-1:0] period;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   sent_id;
    logic [TimeW-1:0] sent_time;
  } out_t;

  // field order gives the service order as a plain unsigned compare
  typedef struct packed {
    logic [TimeW-1:0]   due;
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] period;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT,
    ST_DN_RD,
    ST_DN_LR,
    ST_DN_CMP
  } state_e;

endpackage

`default_nettype wire

FILE: design/phs_cmp.sv
// Shared entry comparator: earlier due time, then smaller id, then smaller period.
// Depends on phs_pkg.
`default_nettype none

module phs_cmp import phs_pkg::*; (
  input  entry_t a_i,
  input  entry_t b_i,
  output logic   before_o
);

  assign before_o = (a_i < b_i);

endmodule

`default_nettype wire

FILE: design/periodic_heap_scheduler.sv
// Periodic client scheduler kept as a binary min-heap in one RAM, sifted by a sequencer.
// An add climbs from the new leaf and reports once the entry settles; a next reports the root
//   as it takes it; clear, full, empty and unused kinds report straight from idle. No result stalls.
// Busy drops as an add's result shows; a next stays busy until the new root entry has sunk.
// Reset clears the entry count, result valid and sequencer only; heap RAM is not initialised.
`default_nettype none
`include "periodic_heap_scheduler_defines.svh"

module periodic_heap_scheduler import phs_pkg::*; #(
  parameter int unsigned MAX_CLIENTS = 1024
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  output logic busy,
  input  in_t  req_i,
  output logic result_valid_o,
  output out_t result_o
);

  localparam int unsigned AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_CLIENTS);

  // heap RAM: one write port, two registered read ports
  entry_t mem_q [MAX_CLIENTS];
  entry_t rd_a_q, rd_b_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, rd_addr_a, rd_addr_b;
  entry_t          mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] i_q, i_d, par_q, par_d, cidx_q, cidx_d;
  entry_t        cur_q, cur_d, child_q, child_d;
  logic          has_r_q, has_r_d;
  logic          res_valid_q, res_valid_d;
  out_t          res_q, res_d;

  entry_t cmp_a, cmp_b;
  logic   cmp_before;

  phs_cmp u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .before_o (cmp_before)
  );

  logic          accept;
  logic [AW+1:0] left_w, right_w;
  logic [AW-1:0] i_m1;
  logic [TimeW:0] due_sum;
  entry_t        new_entry;

  assign accept  = start && !busy;
  assign left_w  = {1'b0, i_q, 1'b1};
  assign right_w = left_w + (AW+2)'(1);
  assign i_m1    = i_q - AW'(1);
  assign due_sum = {1'b0, rd_a_q.due} + (TimeW+1)'(rd_a_q.period);

  always_comb begin
    new_entry.due    = TimeW'(req_i.period);
    new_entry.id     = req_i.client_id;
    new_entry.period = req_i.period;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    par_d       = par_q;
    cidx_d      = cidx_q;
    cur_d       = cur_q;
    child_d     = child_q;
    has_r_d     = has_r_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = cur_q;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    cmp_a       = cur_q;
    cmp_b       = rd_a_q;

    unique case (state_q)
      ST_IDLE: begin
        // root read runs while idle so a next transaction finds it ready
        if (accept) begin
          res_d = '0;
          unique case (req_i.kind)
            KIND_ADD: begin
              if (count_q == MaxCount) begin
                res_valid_d  = 1'b1;
                res_d.status = STATUS_FULL;
              end else begin
                cur_d   = new_entry;
                i_d     = count_q[AW-1:0];
                count_d = count_q + CW'(1);
                state_d = ST_UP_RD;
              end
            end
            KIND_NEXT: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = STATUS_EMPTY;
              end else begin
                state_d = ST_ROOT;
              end
            end
            KIND_CLEAR: begin
              count_d      = '0;
              res_valid_d  = 1'b1;
              res_d.status = STATUS_OK;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_d.status = STATUS_OK;
            end
          endcase
        end
      end

      ST_UP_RD: begin
        if (i_q == '0) begin
          mem_we       = 1'b1;
          res_valid_d  = 1'b1;
          res_d.status = STATUS_OK;
          state_d      = ST_IDLE;
        end else begin
          par_d     = i_m1 >> 1;
          rd_addr_a = i_m1 >> 1;
          state_d   = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        cmp_a = cur_q;
        cmp_b = rd_a_q;
        mem_we = 1'b1;
        if (cmp_before) begin
          // parent moves down into the hole
          mem_wdata = rd_a_q;
          i_d       = par_q;
          state_d   = ST_UP_RD;
        end else begin
          res_valid_d  = 1'b1;
          res_d.status = STATUS_OK;
          state_d      = ST_IDLE;
        end
      end

      ST_ROOT: begin
        res_valid_d     = 1'b1;
        res_d.status    = STATUS_SENT;
        res_d.sent_id   = rd_a_q.id;
        res_d.sent_time = rd_a_q.due;
        cur_d           = rd_a_q;
        cur_d.due       = due_sum[TimeW] ? TIME_MAX : due_sum[TimeW-1:0];
        i_d             = '0;
        state_d         = ST_DN_RD;
      end

      ST_DN_RD: begin
        if (left_w >= {1'b0, count_q}) begin
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rd_addr_a = left_w[AW-1:0];
          rd_addr_b = right_w[AW-1:0];
          has_r_d   = (right_w < {1'b0, count_q});
          cidx_d    = left_w[AW-1:0];
          state_d   = ST_DN_LR;
        end
      end

      ST_DN_LR: begin
        cmp_a = rd_b_q;
        cmp_b = rd_a_q;
        if (has_r_q && cmp_before) begin
          child_d = rd_b_q;
          cidx_d  = cidx_q + AW'(1);
        end else begin
          child_d = rd_a_q;
        end
        state_d = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        cmp_a  = child_q;
        cmp_b  = cur_q;
        mem_we = 1'b1;
        if (cmp_before) begin
          mem_wdata = child_q;
          i_d       = cidx_q;
          state_d   = ST_DN_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    par_q   <= par_d;
    cidx_q  <= cidx_d;
    cur_q   <= cur_d;
    child_q <= child_d;
    has_r_q <= has_r_d;
    res_q   <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `PHS_ASSERT(a_count_bound, count_q <= MaxCount, "entry count exceeds capacity")
  `PHS_ASSERT(a_no_write_idle, (state_q == ST_IDLE) |-> !mem_we, "heap write while idle")
  `PHS_ASSERT(a_hole_in_range,
              (state_q != ST_IDLE && state_q != ST_ROOT) |-> ({1'b0, i_q} < count_q),
              "sift index outside heap")
  `PHS_ASSERT(a_next_reports,
              (accept && req_i.kind == KIND_NEXT && count_q != '0)
                |-> ##2 (res_valid_q && res_q.status == STATUS_SENT),
              "next transaction did not report in time")
  `PHS_ASSERT(a_clear_empties,
              (accept && req_i.kind == KIND_CLEAR) |=> (count_q == '0),
              "clear left entries behind")
  `PHS_ASSERT_ALWAYS(a_reset_idle,
                     !rst_ni |-> (state_q == ST_IDLE && !res_valid_q),
                     "not idle in reset")

endmodule

`default_nettype wire
